/* sv/adt_pkg.sv */
// ============================================================================
// adt_pkg
// Shared types and constants for the knob/battery block averager.
// ============================================================================
`default_nettype none

package adt_pkg;

    localparam int SAMPLE_W = 12;
    localparam int SUM_W    = 18;
    localparam int PCT_W    = 9;
    localparam int MHZ_W    = 9;
    localparam int TENTHS_W = 4;
    localparam int CFG_W    = 12;

    localparam logic [11:0] DEADBAND_RST  = 12'd80;
    localparam logic [7:0]  BATT_OFS_RST  = 8'd60;
    localparam logic [7:0]  TUNE_BASE_RST = 8'd76;
    localparam logic [7:0]  TUNE_SPAN_RST = 8'd33;
    localparam logic [8:0]  MHZ_RST       = 9'd76;

    localparam logic [7:0]  BATT_GAIN  = 8'd198;
    localparam logic [19:0] BATT_FLOOR = 20'd368550;
    localparam logic [3:0]  TENTHS_MUL = 4'd10;

    // x*100/147420 == 5x/7371; reciprocal exact for 22-bit numerators
    localparam int                BATT_SHIFT  = 35;
    localparam longint unsigned   BATT_RECIP_L = ((64'd1 << BATT_SHIFT) + 64'd7370) / 64'd7371;
    localparam logic [22:0]       BATT_RECIP  = 23'(BATT_RECIP_L);

    // divide by full scale 4095; exact for 20-bit numerators
    localparam int                SCALE_SHIFT  = 32;
    localparam longint unsigned   SCALE_RECIP_L = ((64'd1 << SCALE_SHIFT) + 64'd4094) / 64'd4095;
    localparam logic [20:0]       SCALE_RECIP  = 21'(SCALE_RECIP_L);

    typedef enum logic [1:0] {
        CFG_DEADBAND  = 2'd0,
        CFG_BATT_OFS  = 2'd1,
        CFG_TUNE_BASE = 2'd2,
        CFG_TUNE_SPAN = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [11:0] level_sample;
        logic [11:0] battery_sample;
        logic        precision_mode;
    } sample_t;

    typedef struct packed {
        logic [11:0] filtered_level;
        logic        level_changed;
        logic [8:0]  battery_percent;
        logic [8:0]  tune_mhz;
        logic [3:0]  tune_tenths;
    } result_t;

    typedef struct packed {
        logic [SUM_W-1:0] level_sum;
        logic [SUM_W-1:0] battery_sum;
        logic             precise;
    } block_t;

    typedef struct packed {
        logic [11:0] deadband;
        logic [7:0]  battery_offset;
        logic [7:0]  tune_base;
        logic [7:0]  tune_span;
    } cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MEAN_L,
        ST_MEAN_B,
        ST_BATT_MUL,
        ST_BATT_SUB,
        ST_BATT_DIV,
        ST_EMIT
    } back_state_t;

endpackage

`default_nettype wire

/* sv/adc_average_deadband_battery_tuner.sv */
// ============================================================================
// adc_average_deadband_battery_tuner
// Block averager for knob and battery samples with deadband, battery percent
// and tuning scale; one result item per block of sample pairs.
// ============================================================================
//   channel   handshake         payload
//   samples   push / full       sample (level, battery, precision mode)
//   results   pop / empty       result (level, changed, percent, MHz, tenths)
//   config    cfg_write         cfg_index, cfg_data
//
// One sample item is taken per cycle while full is low; the front accumulator
// never stalls on its own. Each block end walks the back sequencer through
// load, two means, multiply, subtract with tuning divide, battery divide and
// emit, queued behind a 2-entry block queue. full rises only when that queue
// is full; emit holds while the 2-entry result queue is full. Reset clears
// sums, counters, held level and tenths, and loads MHz and config defaults.
// ============================================================================
`default_nettype none

module adc_average_deadband_battery_tuner #(
    parameter int BLOCK_PAIRS = 50
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       push,
    output logic                            full,
    input  wire adt_pkg::sample_t           sample,
    output logic                            empty,
    input  wire logic                       pop,
    output adt_pkg::result_t                result,
    input  wire logic                       cfg_write,
    input  wire logic [1:0]                 cfg_index,
    input  wire logic [adt_pkg::CFG_W-1:0]  cfg_data
);

    localparam int BLK_W = $bits(adt_pkg::block_t);
    localparam int RES_W = $bits(adt_pkg::result_t);

    adt_pkg::cfg_t   cfg_reg;
    adt_pkg::block_t front_blk;
    logic            front_push;
    logic            accept;
    logic            blk_full;
    logic            blk_empty;
    logic            blk_pop;
    logic [BLK_W-1:0] blk_rdata;
    logic            res_full;
    logic            res_push;
    adt_pkg::result_t back_res;
    logic [RES_W-1:0] res_rdata;

    assign full   = blk_full;
    assign accept = push && !blk_full;
    assign result = adt_pkg::result_t'(res_rdata);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.deadband       <= adt_pkg::DEADBAND_RST;
            cfg_reg.battery_offset <= adt_pkg::BATT_OFS_RST;
            cfg_reg.tune_base      <= adt_pkg::TUNE_BASE_RST;
            cfg_reg.tune_span      <= adt_pkg::TUNE_SPAN_RST;
        end
        else if (cfg_write)
        begin
            case (adt_pkg::cfg_index_t'(cfg_index))
                adt_pkg::CFG_DEADBAND:  cfg_reg.deadband       <= cfg_data;
                adt_pkg::CFG_BATT_OFS:  cfg_reg.battery_offset <= cfg_data[7:0];
                adt_pkg::CFG_TUNE_BASE: cfg_reg.tune_base      <= cfg_data[7:0];
                adt_pkg::CFG_TUNE_SPAN: cfg_reg.tune_span      <= cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    adt_front #(
        .BLOCK_PAIRS (BLOCK_PAIRS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .sample   (sample),
        .blk_push (front_push),
        .blk      (front_blk)
    );

    adt_fifo #(
        .WIDTH (BLK_W),
        .DEPTH (2)
    ) u_blk_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (front_push),
        .wdata (front_blk),
        .full  (blk_full),
        .pop   (blk_pop),
        .rdata (blk_rdata),
        .empty (blk_empty)
    );

    adt_back #(
        .BLOCK_PAIRS (BLOCK_PAIRS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .blk_empty (blk_empty),
        .blk       (adt_pkg::block_t'(blk_rdata)),
        .blk_pop   (blk_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (back_res)
    );

    adt_fifo #(
        .WIDTH (RES_W),
        .DEPTH (2)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (back_res),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_rdata),
        .empty (empty)
    );

endmodule

`default_nettype wire

/* sv/adt_fifo.sv */
// ============================================================================
// adt_fifo
// Small register queue with full/empty flags and a combinational head.
// ============================================================================
`default_nettype none

module adt_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      rdata,
    output logic                  empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg;
    logic [AW-1:0]    rd_ptr_next;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

/* sv/adt_front.sv */
// ============================================================================
// adt_front
// Sums knob and battery samples over one block and hands off the block sums.
// ============================================================================
`default_nettype none

module adt_front #(
    parameter int BLOCK_PAIRS = 50
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             accept,
    input  wire adt_pkg::sample_t sample,
    output logic                  blk_push,
    output adt_pkg::block_t       blk
);

    localparam int CNT_W = $clog2(BLOCK_PAIRS + 1);

    logic [CNT_W-1:0]          cnt_reg;
    logic [CNT_W-1:0]          cnt_next;
    logic [adt_pkg::SUM_W-1:0] lsum_reg;
    logic [adt_pkg::SUM_W-1:0] lsum_next;
    logic [adt_pkg::SUM_W-1:0] bsum_reg;
    logic [adt_pkg::SUM_W-1:0] bsum_next;
    logic [adt_pkg::SUM_W-1:0] lsum_add;
    logic [adt_pkg::SUM_W-1:0] bsum_add;
    logic                      last;

    assign lsum_add = lsum_reg + adt_pkg::SUM_W'(sample.level_sample);
    assign bsum_add = bsum_reg + adt_pkg::SUM_W'(sample.battery_sample);
    assign last     = (cnt_reg == CNT_W'(BLOCK_PAIRS - 1));

    assign blk_push        = accept && last;
    assign blk.level_sum   = lsum_add;
    assign blk.battery_sum = bsum_add;
    assign blk.precise     = sample.precision_mode;

    always_comb
    begin
        cnt_next  = cnt_reg;
        lsum_next = lsum_reg;
        bsum_next = bsum_reg;
        if (accept)
        begin
            if (last)
            begin
                cnt_next  = '0;
                lsum_next = '0;
                bsum_next = '0;
            end
            else
            begin
                cnt_next  = cnt_reg + 1'b1;
                lsum_next = lsum_add;
                bsum_next = bsum_add;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            lsum_reg <= '0;
            bsum_reg <= '0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            lsum_reg <= lsum_next;
            bsum_reg <= bsum_next;
        end
    end

endmodule

`default_nettype wire

/* sv/adt_back.sv */
// ============================================================================
// adt_back
// Per-block sequencer: means, deadband decision, tuning scale, battery percent.
// ============================================================================
`default_nettype none

module adt_back #(
    parameter int BLOCK_PAIRS = 50
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire adt_pkg::cfg_t   cfg,
    input  wire logic            blk_empty,
    input  wire adt_pkg::block_t blk,
    output logic                 blk_pop,
    input  wire logic            res_full,
    output logic                 res_push,
    output adt_pkg::result_t     res
);

    localparam int              RECIP_W     = adt_pkg::SUM_W + 1;
    localparam int              DIV_SHIFT   = adt_pkg::SUM_W + $clog2(BLOCK_PAIRS);
    localparam longint unsigned DIV_RECIP_L =
        ((64'd1 << DIV_SHIFT) + 64'(BLOCK_PAIRS) - 64'd1) / 64'(BLOCK_PAIRS);
    localparam logic [RECIP_W-1:0] DIV_RECIP = RECIP_W'(DIV_RECIP_L);
    localparam int              PROD_W      = adt_pkg::SUM_W + RECIP_W;

    adt_pkg::back_state_t state_reg;
    adt_pkg::back_state_t state_next;

    logic [adt_pkg::SUM_W-1:0] lsum_reg;
    logic [adt_pkg::SUM_W-1:0] bsum_reg;
    logic                      precise_reg;
    logic [11:0]               mean_l_reg;
    logic [11:0]               mean_b_reg;
    logic                      changed_reg;
    logic [20:0]               scaled_reg;
    logic [19:0]               scale_prod_reg;
    logic [21:0]               n5_reg;
    logic [8:0]                quot_reg;
    logic [8:0]                pct_reg;
    logic [11:0]               held_level_reg;
    logic [8:0]                mhz_reg;
    logic [3:0]                tenths_reg;

    logic [PROD_W-1:0]         mean_l_prod;
    logic [PROD_W-1:0]         mean_b_prod;
    logic [12:0]               upper_bound;
    logic [12:0]               lower_sum;
    logic [7:0]                scale_mul;
    logic [19:0]               batt_diff;
    logic [40:0]               quot_prod;
    logic [44:0]               pct_prod;

    assign mean_l_prod = PROD_W'(lsum_reg) * PROD_W'(DIV_RECIP);
    assign mean_b_prod = PROD_W'(bsum_reg) * PROD_W'(DIV_RECIP);
    assign upper_bound = 13'(held_level_reg) + 13'(cfg.deadband);
    assign lower_sum   = 13'(mean_l_reg) + 13'(cfg.deadband);
    assign scale_mul   = precise_reg ? cfg.tune_span : 8'(adt_pkg::TENTHS_MUL);
    assign batt_diff   = 20'(scaled_reg - 21'(adt_pkg::BATT_FLOOR));
    assign quot_prod   = 41'(scale_prod_reg) * 41'(adt_pkg::SCALE_RECIP);
    assign pct_prod    = 45'(n5_reg) * 45'(adt_pkg::BATT_RECIP);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            adt_pkg::ST_IDLE:
            begin
                if (!blk_empty)
                begin
                    state_next = adt_pkg::ST_MEAN_L;
                end
            end
            adt_pkg::ST_MEAN_L:   state_next = adt_pkg::ST_MEAN_B;
            adt_pkg::ST_MEAN_B:   state_next = adt_pkg::ST_BATT_MUL;
            adt_pkg::ST_BATT_MUL: state_next = adt_pkg::ST_BATT_SUB;
            adt_pkg::ST_BATT_SUB: state_next = adt_pkg::ST_BATT_DIV;
            adt_pkg::ST_BATT_DIV: state_next = adt_pkg::ST_EMIT;
            adt_pkg::ST_EMIT:
            begin
                if (!res_full)
                begin
                    state_next = adt_pkg::ST_IDLE;
                end
            end
            default:              state_next = adt_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        blk_pop  = 1'b0;
        res_push = 1'b0;
        case (state_reg)
            adt_pkg::ST_IDLE: blk_pop  = !blk_empty;
            adt_pkg::ST_EMIT: res_push = !res_full;
            default:
            begin
                blk_pop  = 1'b0;
                res_push = 1'b0;
            end
        endcase
    end

    assign res.filtered_level  = held_level_reg;
    assign res.level_changed   = changed_reg;
    assign res.battery_percent = pct_reg;
    assign res.tune_mhz        = mhz_reg;
    assign res.tune_tenths     = tenths_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= adt_pkg::ST_IDLE;
            held_level_reg <= '0;
            mhz_reg        <= adt_pkg::MHZ_RST;
            tenths_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == adt_pkg::ST_BATT_MUL && changed_reg)
            begin
                held_level_reg <= mean_l_reg;
            end
            if (state_reg == adt_pkg::ST_BATT_DIV && changed_reg)
            begin
                if (precise_reg)
                begin
                    mhz_reg <= 9'(cfg.tune_base) + quot_reg;
                end
                else
                begin
                    tenths_reg <= quot_reg[3:0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            adt_pkg::ST_IDLE:
            begin
                lsum_reg    <= blk.level_sum;
                bsum_reg    <= blk.battery_sum;
                precise_reg <= blk.precise;
            end
            adt_pkg::ST_MEAN_L:
            begin
                mean_l_reg <= mean_l_prod[DIV_SHIFT +: 12];
            end
            adt_pkg::ST_MEAN_B:
            begin
                mean_b_reg  <= mean_b_prod[DIV_SHIFT +: 12];
                changed_reg <= (13'(mean_l_reg) > upper_bound)
                            || (lower_sum < 13'(held_level_reg));
            end
            adt_pkg::ST_BATT_MUL:
            begin
                scaled_reg     <= 21'(13'(mean_b_reg) + 13'(cfg.battery_offset))
                                * 21'(adt_pkg::BATT_GAIN);
                scale_prod_reg <= 20'(mean_l_reg) * 20'(scale_mul);
            end
            adt_pkg::ST_BATT_SUB:
            begin
                n5_reg   <= (scaled_reg > 21'(adt_pkg::BATT_FLOOR))
                          ? (22'(batt_diff) << 2) + 22'(batt_diff) : '0;
                quot_reg <= quot_prod[adt_pkg::SCALE_SHIFT +: 9];
            end
            adt_pkg::ST_BATT_DIV:
            begin
                pct_reg <= pct_prod[adt_pkg::BATT_SHIFT +: 9];
            end
            default:
            begin
            end
        endcase
    end

endmodule

`default_nettype wire

/* sim/adc_average_deadband_battery_tuner_test.sv */
`timescale 1ns / 100ps
// ============================================================================
// adc_average_deadband_battery_tuner_test
// Self-checking bench for the knob/battery block averager. A directed table
// walks full-scale, zero, deadband-edge and battery-knee blocks. Random
// phases follow under varied register settings with random idling on both
// sides. Each result item is checked field by field against its table entry
// or an in-bench model of block average, deadband, battery percent, tuning scale.
// ============================================================================

module adc_average_deadband_battery_tuner_test;

    localparam int N_PAIRS      = 50;
    localparam int RANDOM_ITEMS = 1300;
    localparam int HOLD_ITEMS   = 400;
    localparam int SETTLE       = 20;
    localparam int HOLD_CYCLES  = 600;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int SUM_WRAP     = 1 << adt_pkg::SUM_W;
    localparam int KNOB_FULL    = 4095;
    localparam int BAT_MUL      = 198;
    localparam int BAT_FLOOR_V  = 368550;
    localparam int BAT_DIV      = 147420;
    localparam int BAT_KNEE     = 1862;

    typedef struct packed {
        adt_pkg::sample_t s;
        bit               typed;
        adt_pkg::result_t want;
    } plan_row_t;

    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      push      = 1'b0;
    logic                      full;
    adt_pkg::sample_t          sample    = '0;
    logic                      empty;
    logic                      pop       = 1'b0;
    adt_pkg::result_t          result;
    logic                      cfg_write = 1'b0;
    logic [1:0]                cfg_index = adt_pkg::CFG_DEADBAND;
    logic [adt_pkg::CFG_W-1:0] cfg_data  = '0;

    int dead    = adt_pkg::DEADBAND_RST;
    int bat_ofs = adt_pkg::BATT_OFS_RST;
    int t_base  = adt_pkg::TUNE_BASE_RST;
    int t_span  = adt_pkg::TUNE_SPAN_RST;

    int acc_pairs  = 0;
    int knob_total = 0;
    int batt_total = 0;
    int held       = 0;
    int mhz_now    = adt_pkg::MHZ_RST;
    int tenths_now = 0;

    int knob_aim   = 0;
    int batt_aim   = 0;
    bit knob_wild  = 1'b1;
    bit batt_wild  = 1'b1;

    adt_pkg::result_t expected_results[$];
    plan_row_t        plan[$];

    int bad_count    = 0;
    int cycle_count  = 0;
    int random_sent  = 0;
    bit tx_gaps      = 1'b1;
    bit rx_gaps      = 1'b1;
    bit hold_req     = 1'b0;
    bit hold_done    = 1'b0;
    int hold_left    = 0;

    adc_average_deadband_battery_tuner #(
        .BLOCK_PAIRS (N_PAIRS)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .sample    (sample),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic logic [11:0] clamp12(input int v);
        if (v < 0)
            return 12'd0;
        if (v > KNOB_FULL)
            return 12'(KNOB_FULL);
        return 12'(v);
    endfunction

    task automatic average_block(input adt_pkg::sample_t s, output bit done,
                                 output adt_pkg::result_t r);
        int knob_mean;
        int batt_mean;
        int scaled;
        int pct;
        bit moved;
        knob_total = (knob_total + s.level_sample) % SUM_WRAP;
        batt_total = (batt_total + s.battery_sample) % SUM_WRAP;
        acc_pairs  = acc_pairs + 1;
        done = 1'b0;
        r    = '0;
        if (acc_pairs >= N_PAIRS)
        begin
            knob_mean  = knob_total / N_PAIRS;
            batt_mean  = batt_total / N_PAIRS;
            acc_pairs  = 0;
            knob_total = 0;
            batt_total = 0;
            moved = (knob_mean > held + dead) || (knob_mean + dead < held);
            if (moved)
            begin
                held = knob_mean % (KNOB_FULL + 1);
                if (s.precision_mode)
                    mhz_now = (t_base + (held * t_span) / KNOB_FULL) % 512;
                else
                    tenths_now = ((held * 10) / KNOB_FULL) % 16;
            end
            scaled = (batt_mean + bat_ofs) * BAT_MUL;
            pct = (scaled > BAT_FLOOR_V) ? ((scaled - BAT_FLOOR_V) * 100) / BAT_DIV : 0;
            r.filtered_level  = 12'(held);
            r.level_changed   = moved;
            r.battery_percent = 9'(pct);
            r.tune_mhz        = 9'(mhz_now);
            r.tune_tenths     = 4'(tenths_now);
            done = 1'b1;
        end
    endtask

    // aim knob near deadband edges in most blocks, battery near the knee in half
    task automatic next_sample(output adt_pkg::sample_t s);
        int pick;
        if (acc_pairs == 0)
        begin
            pick      = $urandom_range(0, 9);
            knob_wild = (pick < 4);
            knob_aim  = ((pick < 7) ? held + dead : held - dead)
                        + int'($urandom_range(0, 2)) - 1;
            pick      = $urandom_range(0, 9);
            batt_wild = (pick < 5);
            batt_aim  = BAT_KNEE - bat_ofs + int'($urandom_range(0, 4)) - 2;
        end
        s.level_sample   = knob_wild ? 12'($urandom_range(0, KNOB_FULL))
                                     : clamp12(knob_aim + int'($urandom_range(0, 2)) - 1);
        s.battery_sample = batt_wild ? 12'($urandom_range(0, KNOB_FULL))
                                     : clamp12(batt_aim + int'($urandom_range(0, 2)) - 1);
        s.precision_mode = 1'($urandom_range(0, 1));
    endtask

    task automatic send_item(input adt_pkg::sample_t s, input bit typed,
                             input adt_pkg::result_t want);
        bit               done;
        adt_pkg::result_t r;
        while (tx_gaps && $urandom_range(0, 99) < 35)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push   <= 1'b1;
        sample <= s;
        @(posedge clk);
        while (full)
            @(posedge clk);
        average_block(s, done, r);
        if (done)
            expected_results.push_back(typed ? want : r);
        @(negedge clk);
    endtask

    task automatic wait_idle();
        push <= 1'b0;
        @(negedge clk);
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_reg(input adt_pkg::cfg_index_t idx, input int val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        case (idx)
            adt_pkg::CFG_DEADBAND:
            begin
                cfg_data <= val[11:0];
                dead = val % 4096;
            end
            adt_pkg::CFG_BATT_OFS:
            begin
                cfg_data <= {4'($urandom), val[7:0]};
                bat_ofs = val % 256;
            end
            adt_pkg::CFG_TUNE_BASE:
            begin
                cfg_data <= {4'($urandom), val[7:0]};
                t_base = val % 256;
            end
            default:
            begin
                cfg_data <= {4'($urandom), val[7:0]};
                t_span = val % 256;
            end
        endcase
        @(negedge clk);
    endtask

    task automatic plan_block(input logic [11:0] lvl, input logic [11:0] bat,
                              input logic prec, input bit typed,
                              input adt_pkg::result_t want);
        plan_row_t row;
        int        i;
        row.s.level_sample   = lvl;
        row.s.battery_sample = bat;
        row.s.precision_mode = prec;
        row.want             = want;
        for (i = 0; i < N_PAIRS; i++)
        begin
            row.typed = typed && (i == N_PAIRS - 1);
            plan.push_back(row);
        end
    endtask

    always @(negedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else if (hold_left != 0)
        begin
            pop       <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_req && !hold_done)
        begin
            pop       <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else
            pop <= !(rx_gaps && $urandom_range(0, 99) < 35);
    end

    function automatic void field_check(input string name, input logic [11:0] want,
                                        input logic [11:0] got);
        if (want !== got)
        begin
            bad_count++;
            if (bad_count <= 10)
                $display("%s: expected %0d, got %0d", name, want, got);
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (expected_results.size() == 0)
            begin
                bad_count++;
                if (bad_count <= 10)
                    $display("result item with nothing expected: %h", result);
            end
            else
            begin
                field_check("filtered_level", expected_results[0].filtered_level,
                            result.filtered_level);
                field_check("level_changed", 12'(expected_results[0].level_changed),
                            12'(result.level_changed));
                field_check("battery_percent", 12'(expected_results[0].battery_percent),
                            12'(result.battery_percent));
                field_check("tune_mhz", 12'(expected_results[0].tune_mhz),
                            12'(result.tune_mhz));
                field_check("tune_tenths", 12'(expected_results[0].tune_tenths),
                            12'(result.tune_tenths));
                void'(expected_results.pop_front());
            end
        end
    end

    initial
    begin
        int               p;
        int               n;
        int               i;
        int               nd;
        int               no;
        int               nb;
        int               ns;
        adt_pkg::sample_t s;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        plan_block(12'd0, 12'd0, 1'b0, 1'b1, {12'd0, 1'b0, 9'd0, 9'd76, 4'd0});
        plan_block(12'd4095, 12'd4095, 1'b1, 1'b1, {12'd4095, 1'b1, 9'd308, 9'd109, 4'd0});
        plan_block(12'd4095, 12'd4095, 1'b0, 1'b1, {12'd4095, 1'b0, 9'd308, 9'd109, 4'd0});
        plan_block(12'd0, 12'd0, 1'b0, 1'b1, {12'd0, 1'b1, 9'd0, 9'd109, 4'd0});
        plan_block(12'd4095, 12'd4095, 1'b0, 1'b1, {12'd4095, 1'b1, 9'd308, 9'd109, 4'd10});
        plan_block(12'd4015, 12'd1802, 1'b1, 1'b0, '0);
        plan_block(12'd4014, 12'd1801, 1'b1, 1'b0, '0);
        plan_block(12'h555, 12'hAAA, 1'b0, 1'b0, '0);
        plan_block(12'hAAA, 12'h555, 1'b1, 1'b0, '0);
        foreach (plan[k])
            send_item(plan[k].s, plan[k].typed, plan[k].want);
        wait_idle();

        p = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            case (p)
                0:
                begin
                    nd = 0;    no = 0;   nb = 0;   ns = 0;
                end
                1:
                begin
                    nd = 4095; no = 255; nb = 255; ns = 255;
                end
                2:
                begin
                    nd = 0;    no = 255; nb = 255; ns = 255;
                end
                default:
                begin
                    nd = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095)
                                                     : $urandom_range(0, 200);
                    no = $urandom_range(0, 255);
                    nb = $urandom_range(0, 255);
                    ns = $urandom_range(0, 255);
                end
            endcase
            write_reg(adt_pkg::CFG_DEADBAND, nd);
            write_reg(adt_pkg::CFG_BATT_OFS, no);
            write_reg(adt_pkg::CFG_TUNE_BASE, nb);
            write_reg(adt_pkg::CFG_TUNE_SPAN, ns);
            cfg_write <= 1'b0;
            tx_gaps = !(p == 3 || p == 4);
            rx_gaps = (p != 3);
            if (p == 4)
                hold_req = 1'b1;
            n = (p == 4) ? HOLD_ITEMS : $urandom_range(150, 300);
            for (i = 0; i < n; i++)
            begin
                next_sample(s);
                send_item(s, 1'b0, '0);
                random_sent++;
            end
            wait_idle();
            p++;
        end

        if (bad_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
